// ===== design/ncr_pkg.sv =====
`timescale 1ns / 1ps
package ncr_pkg;

  localparam int MetricW = 48;
  localparam int EntryW  = 16;
  localparam int WideW   = 56;
  localparam int TolW    = 25;
  localparam int LimitW  = 16;
  localparam int CntW    = LimitW + 1;
  localparam int StatusW = 2;
  localparam int IdxW    = 1;
  localparam int InW     = 6 * MetricW;
  localparam int OutRawW = 9 * MetricW + StatusW;
  localparam int OutW    = ((OutRawW + 7) / 8) * 8;

  typedef logic signed [MetricW-1:0] metric_t;
  typedef logic signed [WideW-1:0]   wide_t;
  typedef logic signed [EntryW-1:0]  entry_t;
  typedef logic signed [EntryW+1:0]  raw_t;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_LIMIT = 2'd1;
  localparam logic [StatusW-1:0] STATUS_SAT   = 2'd2;

  localparam logic [IdxW-1:0] CFG_TOL   = 1'b0;
  localparam logic [IdxW-1:0] CFG_LIMIT = 1'b1;

  localparam logic [TolW-1:0]   TOL_RESET   = 25'd168;
  localparam logic [LimitW-1:0] LIMIT_RESET = 16'd10000;

  localparam wide_t MET_HI = (wide_t'(1) <<< (MetricW - 1)) - wide_t'(1);
  localparam wide_t MET_LO = -MET_HI - wide_t'(1);
  localparam raw_t  ENT_HI = (raw_t'(1) <<< (EntryW - 1)) - raw_t'(1);
  localparam raw_t  ENT_LO = -ENT_HI - raw_t'(1);

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CHECK, OP_S1, OP_S2, OP_S34, OP_S5, OP_S6, OP_S7, OP_S8
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic c2;
    logic c5;
    logic c6;
    logic c7;
    logic c8;
    logic limit_hit;
    logic out_busy;
  } sts_t;

  function automatic wide_t wext(metric_t v);
    return wide_t'(v);
  endfunction

  function automatic wide_t wabs(wide_t v);
    return (v < wide_t'(0)) ? -v : v;
  endfunction

  // x < y - tol, exact
  function automatic logic lt(wide_t x, wide_t y, logic [TolW-1:0] tol);
    logic signed [WideW+1:0] d;
    d = (WideW+2)'(y) - (WideW+2)'(x);
    return d > $signed({{(WideW+2-TolW){1'b0}}, tol});
  endfunction

  function automatic logic eq(wide_t x, wide_t y, logic [TolW-1:0] tol);
    return !lt(x, y, tol) && !lt(y, x, tol);
  endfunction

  function automatic metric_t clamp_metric(wide_t v);
    wide_t r;
    r = (v > MET_HI) ? MET_HI : ((v < MET_LO) ? MET_LO : v);
    return r[MetricW-1:0];
  endfunction

  function automatic entry_t ent_sat(raw_t v);
    raw_t r;
    r = (v > ENT_HI) ? ENT_HI : ((v < ENT_LO) ? ENT_LO : v);
    return r[EntryW-1:0];
  endfunction

  function automatic logic ent_ovf(raw_t v);
    return (v > ENT_HI) || (v < ENT_LO);
  endfunction

  function automatic raw_t rneg(entry_t e, logic n);
    return n ? -raw_t'(e) : raw_t'(e);
  endfunction

endpackage

// ===== design/ncr_ctrl.sv =====
`timescale 1ns / 1ps
module ncr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ncr_pkg::sts_t sts_i,
  output ncr_pkg::cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CHECK = 10'b0000000010,
    ST_S1    = 10'b0000000100,
    ST_S2    = 10'b0000001000,
    ST_S34   = 10'b0000010000,
    ST_S5    = 10'b0000100000,
    ST_S6    = 10'b0001000000,
    ST_S7    = 10'b0010000000,
    ST_S8    = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = ncr_pkg::OP_NONE;
    cmd_o.out_load  = 1'b0;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ncr_pkg::OP_LOAD;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.op = ncr_pkg::OP_CHECK;
        state_d  = sts_i.limit_hit ? ST_FIN : ST_S1;
      end
      ST_S1: begin
        cmd_o.op = ncr_pkg::OP_S1;
        state_d  = ST_S2;
      end
      ST_S2: begin
        cmd_o.op = ncr_pkg::OP_S2;
        state_d  = sts_i.c2 ? ST_CHECK : ST_S34;
      end
      ST_S34: begin
        cmd_o.op = ncr_pkg::OP_S34;
        state_d  = ST_S5;
      end
      ST_S5: begin
        cmd_o.op = ncr_pkg::OP_S5;
        state_d  = sts_i.c5 ? ST_CHECK : ST_S6;
      end
      ST_S6: begin
        cmd_o.op = ncr_pkg::OP_S6;
        state_d  = sts_i.c6 ? ST_CHECK : ST_S7;
      end
      ST_S7: begin
        cmd_o.op = ncr_pkg::OP_S7;
        state_d  = sts_i.c7 ? ST_CHECK : ST_S8;
      end
      ST_S8: begin
        cmd_o.op = ncr_pkg::OP_S8;
        state_d  = sts_i.c8 ? ST_CHECK : ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/ncr_datapath.sv =====
`timescale 1ns / 1ps
module ncr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ncr_pkg::InW-1:0]        in_data_i,
  input  logic [ncr_pkg::TolW-1:0]       tol_i,
  input  logic [ncr_pkg::LimitW-1:0]     limit_i,
  input  ncr_pkg::cmd_t                  cmd_i,
  output ncr_pkg::sts_t                  sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [ncr_pkg::OutW-1:0]       out_data_o
);

  ncr_pkg::metric_t m_q [6];
  ncr_pkg::entry_t  mat_q [3][3];
  logic [ncr_pkg::CntW-1:0] cnt_q;
  logic fail_q, sat_q, out_valid_q;
  logic [ncr_pkg::OutW-1:0] out_data_q;

  ncr_pkg::wide_t w [6];
  ncr_pkg::wide_t nw [6];
  ncr_pkg::raw_t  raw [3][3];
  ncr_pkg::entry_t mid;
  ncr_pkg::wide_t t8, two0, two1;
  logic c1, c2, c5, c6, c7, c8, app3, ovf_any, is_step;
  logic [2:0] pos, ng, zr, f4, fneg;
  logic [ncr_pkg::CntW-1:0] cnt_inc;
  logic [ncr_pkg::StatusW-1:0] status;
  ncr_pkg::wide_t zero;

  always_comb begin
    zero = ncr_pkg::wide_t'(0);
    for (int i = 0; i < 6; i++) w[i] = ncr_pkg::wext(m_q[i]);
    two0 = w[0] + w[0];
    two1 = w[1] + w[1];

    c1 = ncr_pkg::lt(w[1], w[0], tol_i) || (ncr_pkg::eq(w[0], w[1], tol_i) &&
         ncr_pkg::lt(ncr_pkg::wabs(w[4]), ncr_pkg::wabs(w[3]), tol_i));
    c2 = ncr_pkg::lt(w[2], w[1], tol_i) || (ncr_pkg::eq(w[1], w[2], tol_i) &&
         ncr_pkg::lt(ncr_pkg::wabs(w[5]), ncr_pkg::wabs(w[4]), tol_i));

    for (int i = 0; i < 3; i++) begin
      pos[i] = ncr_pkg::lt(zero, w[3+i], tol_i);
      ng[i]  = ncr_pkg::lt(w[3+i], zero, tol_i);
      zr[i]  = !pos[i] && !ng[i];
    end
    app3 = (pos == 3'b111) ||
           ((zr == 3'b000) && (pos == 3'b001 || pos == 3'b010 || pos == 3'b100));
    f4 = pos;
    if (^pos) begin
      if (zr[2]) f4[2] = 1'b1;
      else if (zr[1]) f4[1] = 1'b1;
      else if (zr[0]) f4[0] = 1'b1;
    end
    fneg = app3 ? ng : f4;

    c5 = ncr_pkg::lt(w[1], ncr_pkg::wabs(w[3]), tol_i) ||
         (ncr_pkg::eq(w[3], w[1], tol_i) && ncr_pkg::lt(w[4] + w[4], w[5], tol_i)) ||
         (ncr_pkg::eq(w[3], -w[1], tol_i) && ncr_pkg::lt(w[5], zero, tol_i));
    c6 = ncr_pkg::lt(w[0], ncr_pkg::wabs(w[4]), tol_i) ||
         (ncr_pkg::eq(w[4], w[0], tol_i) && ncr_pkg::lt(w[3] + w[3], w[5], tol_i)) ||
         (ncr_pkg::eq(w[4], -w[0], tol_i) && ncr_pkg::lt(w[5], zero, tol_i));
    c7 = ncr_pkg::lt(w[0], ncr_pkg::wabs(w[5]), tol_i) ||
         (ncr_pkg::eq(w[5], w[0], tol_i) && ncr_pkg::lt(w[3] + w[3], w[4], tol_i)) ||
         (ncr_pkg::eq(w[5], -w[0], tol_i) && ncr_pkg::lt(w[4], zero, tol_i));
    t8 = w[3] + w[4] + w[5] + w[0] + w[1];
    c8 = ncr_pkg::lt(t8, zero, tol_i) || (ncr_pkg::eq(t8, zero, tol_i) &&
         ncr_pkg::lt(zero, two0 + w[4] + w[4] + w[5], tol_i));

    for (int i = 0; i < 6; i++) nw[i] = w[i];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) raw[r][c] = ncr_pkg::raw_t'(mat_q[r][c]);
    ovf_any = 1'b0;
    mid     = '0;
    is_step = 1'b1;

    case (cmd_i.op)
      ncr_pkg::OP_S1: begin
        if (c1) begin
          nw[0] = w[1]; nw[1] = w[0]; nw[3] = w[4]; nw[4] = w[3];
          for (int r = 0; r < 3; r++) begin
            raw[r][0] = ncr_pkg::rneg(mat_q[r][1], 1'b1);
            raw[r][1] = ncr_pkg::rneg(mat_q[r][0], 1'b1);
            raw[r][2] = ncr_pkg::rneg(mat_q[r][2], 1'b1);
          end
        end
      end
      ncr_pkg::OP_S2: begin
        if (c2) begin
          nw[1] = w[2]; nw[2] = w[1]; nw[4] = w[5]; nw[5] = w[4];
          for (int r = 0; r < 3; r++) begin
            raw[r][0] = ncr_pkg::rneg(mat_q[r][0], 1'b1);
            raw[r][1] = ncr_pkg::rneg(mat_q[r][2], 1'b1);
            raw[r][2] = ncr_pkg::rneg(mat_q[r][1], 1'b1);
          end
        end
      end
      ncr_pkg::OP_S34: begin
        for (int i = 0; i < 3; i++) begin
          nw[3+i] = app3 ? ncr_pkg::wabs(w[3+i]) : -ncr_pkg::wabs(w[3+i]);
          for (int r = 0; r < 3; r++) raw[r][i] = ncr_pkg::rneg(mat_q[r][i], fneg[i]);
        end
      end
      ncr_pkg::OP_S5: begin
        if (c5) begin
          nw[2] = w[1] + w[2] - ncr_pkg::wabs(w[3]);
          if (w[3] > zero) begin
            nw[4] = w[4] - w[5];
            nw[3] = w[3] - two1;
            for (int r = 0; r < 3; r++) raw[r][2] = raw[r][2] - raw[r][1];
          end else if (w[3] < zero) begin
            nw[4] = w[4] + w[5];
            nw[3] = w[3] + two1;
            for (int r = 0; r < 3; r++) raw[r][2] = raw[r][2] + raw[r][1];
          end
        end
      end
      ncr_pkg::OP_S6: begin
        if (c6) begin
          nw[2] = w[0] + w[2] - ncr_pkg::wabs(w[4]);
          if (w[4] > zero) begin
            nw[3] = w[3] - w[5];
            nw[4] = w[4] - two0;
            for (int r = 0; r < 3; r++) raw[r][2] = raw[r][2] - raw[r][0];
          end else if (w[4] < zero) begin
            nw[3] = w[3] + w[5];
            nw[4] = w[4] + two0;
            for (int r = 0; r < 3; r++) raw[r][2] = raw[r][2] + raw[r][0];
          end
        end
      end
      ncr_pkg::OP_S7: begin
        if (c7) begin
          nw[1] = w[0] + w[1] - ncr_pkg::wabs(w[5]);
          if (w[5] > zero) begin
            nw[3] = w[3] - w[4];
            nw[5] = w[5] - two0;
            for (int r = 0; r < 3; r++) raw[r][1] = raw[r][1] - raw[r][0];
          end else if (w[5] < zero) begin
            nw[3] = w[3] + w[4];
            nw[5] = w[5] + two0;
            for (int r = 0; r < 3; r++) raw[r][1] = raw[r][1] + raw[r][0];
          end
        end
      end
      ncr_pkg::OP_S8: begin
        if (c8) begin
          nw[2] = w[2] + t8;
          nw[3] = two1 + w[3] + w[5];
          nw[4] = two0 + w[4] + w[5];
          for (int r = 0; r < 3; r++) begin
            mid = ncr_pkg::ent_sat(raw[r][2] + raw[r][0]);
            ovf_any = ovf_any | ncr_pkg::ent_ovf(raw[r][2] + raw[r][0]);
            raw[r][2] = ncr_pkg::raw_t'(mid) + raw[r][1];
          end
        end
      end
      default: is_step = 1'b0;
    endcase

    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) ovf_any = ovf_any | ncr_pkg::ent_ovf(raw[r][c]);

    cnt_inc = cnt_q + ncr_pkg::CntW'(1);
    status  = fail_q ? ncr_pkg::STATUS_LIMIT :
              (sat_q ? ncr_pkg::STATUS_SAT : ncr_pkg::STATUS_OK);

    sts_o.c2        = c2;
    sts_o.c5        = c5;
    sts_o.c6        = c6;
    sts_o.c7        = c7;
    sts_o.c8        = c8;
    sts_o.limit_hit = cnt_inc > ncr_pkg::CntW'(limit_i);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ncr_pkg::OP_LOAD) begin
      for (int i = 0; i < 6; i++) m_q[i] <= in_data_i[i*ncr_pkg::MetricW +: ncr_pkg::MetricW];
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          mat_q[r][c] <= (r == c) ? ncr_pkg::entry_t'(1) : ncr_pkg::entry_t'(0);
    end else if (is_step) begin
      for (int i = 0; i < 6; i++) m_q[i] <= ncr_pkg::clamp_metric(nw[i]);
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) mat_q[r][c] <= ncr_pkg::ent_sat(raw[r][c]);
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{(ncr_pkg::OutW - ncr_pkg::OutRawW){1'b0}}, status,
                     mat_q[2][2], mat_q[1][2], mat_q[0][2],
                     mat_q[2][1], mat_q[1][1], mat_q[0][1],
                     mat_q[2][0], mat_q[1][0], mat_q[0][0],
                     m_q[5], m_q[4], m_q[3], m_q[2], m_q[1], m_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fail_q      <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == ncr_pkg::OP_LOAD) begin
        cnt_q  <= '0;
        fail_q <= 1'b0;
        sat_q  <= 1'b0;
      end else if (cmd_i.op == ncr_pkg::OP_CHECK) begin
        cnt_q <= cnt_inc;
        if (sts_o.limit_hit) fail_q <= 1'b1;
      end else if (is_step && ovf_any) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/niggli_cell_reduction_unit.sv =====
`timescale 1ns / 1ps
// Channel    Dir  Handshake                      Payload
// s_axis     in   s_axis_tvalid_i/s_axis_tready_o  metric a,b,c,xi,eta,zeta
// m_axis     out  m_axis_tvalid_o/m_axis_tready_i  reduced metric, columns, status
// cfg        in   cfg_we_i                         cfg_idx_i, cfg_data_i
//
// One reduction step per cycle: a pass is a check state plus up to seven step
// states, and an item also passes an accept state and a finish state. The step
// sequencer in ncr_ctrl orders the states; the finish state waits while the
// result register still holds an unaccepted result, and the result register lets
// the next item start while a result waits. Reset is asynchronous, active low,
// and leaves tolerance 168 and iteration limit 10000.
module niggli_cell_reduction_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // metric_a, metric_b, metric_c, metric_xi, metric_eta, metric_zeta
  input  logic [ncr_pkg::InW-1:0]       s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // reduced_a..reduced_zeta, basis_column_0..2, status
  output logic [ncr_pkg::OutW-1:0]      m_axis_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [ncr_pkg::IdxW-1:0]      cfg_idx_i,
  input  logic [ncr_pkg::TolW-1:0]      cfg_data_i
);

  logic [ncr_pkg::TolW-1:0]   tol_q;
  logic [ncr_pkg::LimitW-1:0] limit_q;
  ncr_pkg::cmd_t cmd;
  ncr_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= ncr_pkg::TOL_RESET;
      limit_q <= ncr_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ncr_pkg::CFG_TOL:   tol_q   <= cfg_data_i;
        ncr_pkg::CFG_LIMIT: limit_q <= cfg_data_i[ncr_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  ncr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ncr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .tol_i       (tol_q),
    .limit_i     (limit_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == ncr_pkg::OP_LOAD) |-> (s_axis_tvalid_i && s_axis_tready_o))
    else $error("load without input transaction");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !sts.out_busy)
    else $error("result register overwritten");

endmodule

// ===== verif/niggli_cell_reduction_checker.sv =====
`timescale 1ns / 1ps
module niggli_cell_reduction_checker
  import ncr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InW-1:0]      s_data_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutW-1:0]     m_data_i,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [TolW-1:0]     cfg_data_i,
  output int                  error_count_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  limit_hits_o,
  output int                  saturations_o
);

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic [2:0][47:0]         col;
    logic [5:0][MetricW-1:0]  met;
  } reduction_t;

  localparam longint LMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LMin = 64'sh8000_0000_0000_0000;

  logic [TolW-1:0]   tol_q;
  logic [LimitW-1:0] limit_q;
  reduction_t        expected_q[$];
  int                basis[9];
  bit                entry_clipped;

  function automatic longint sadd(longint a, longint b);
    logic signed [64:0] w;
    w = {a[63], a} + {b[63], b};
    return (w[64] != w[63]) ? (w[64] ? LMin : LMax) : longint'(w[63:0]);
  endfunction

  function automatic longint ssub(longint a, longint b);
    logic signed [64:0] w;
    w = {a[63], a} - {b[63], b};
    return (w[64] != w[63]) ? (w[64] ? LMin : LMax) : longint'(w[63:0]);
  endfunction

  function automatic longint sneg(longint a);
    return (a == LMin) ? LMax : -a;
  endfunction

  function automatic longint sabs(longint a);
    return (a < 0) ? sneg(a) : a;
  endfunction

  function automatic int sgn(longint a);
    return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
  endfunction

  function automatic longint subsgn(longint a, longint b, int s);
    if (s > 0) return ssub(a, b);
    if (s < 0) return sadd(a, b);
    return a;
  endfunction

  function automatic longint clip_metric(longint v);
    longint hi;
    hi = (64'sd1 <<< (MetricW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // x < y - tolerance
  function automatic bit lt(longint x, longint y);
    logic [63:0] d;
    if (y <= x) return 1'b0;
    d = y - x;
    return d > {{(64 - TolW){1'b0}}, tol_q};
  endfunction

  function automatic bit gt(longint x, longint y);
    return lt(y, x);
  endfunction

  function automatic bit eq(longint x, longint y);
    return !lt(x, y) && !lt(y, x);
  endfunction

  function automatic int clip_entry(int v);
    int hi;
    hi = (1 << (EntryW - 1)) - 1;
    if (v > hi) begin
      entry_clipped = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      entry_clipped = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic void col_addmul(int dst, int src, int k);
    for (int r = 0; r < 3; r++)
      basis[r*3+dst] = clip_entry(basis[r*3+dst] + k * basis[r*3+src]);
  endfunction

  function automatic void col_permute(int i0, int i1, int i2, int s0, int s1, int s2);
    int old[9];
    old = basis;
    for (int r = 0; r < 3; r++) begin
      basis[r*3]   = clip_entry(s0 * old[r*3+i0]);
      basis[r*3+1] = clip_entry(s1 * old[r*3+i1]);
      basis[r*3+2] = clip_entry(s2 * old[r*3+i2]);
    end
  endfunction

  function automatic reduction_t reduce_metric(logic [InW-1:0] data);
    reduction_t        res;
    longint            m[6];
    longint            t;
    int                s, pos, zero, p;
    int                f[3];
    int unsigned       restarts;
    logic [StatusW-1:0] st;
    for (int i = 0; i < 6; i++) m[i] = $signed(data[i*MetricW +: MetricW]);
    for (int i = 0; i < 9; i++) basis[i] = (i % 4 == 0) ? 1 : 0;
    entry_clipped = 1'b0;
    restarts = 0;
    st = STATUS_OK;
    while (1) begin
      restarts++;
      if (restarts > limit_q) begin
        st = STATUS_LIMIT;
        break;
      end
      if (gt(m[0], m[1]) || (eq(m[0], m[1]) && gt(sabs(m[3]), sabs(m[4])))) begin
        col_permute(1, 0, 2, -1, -1, -1);
        t = m[0]; m[0] = m[1]; m[1] = t;
        t = m[3]; m[3] = m[4]; m[4] = t;
      end
      if (gt(m[1], m[2]) || (eq(m[1], m[2]) && gt(sabs(m[4]), sabs(m[5])))) begin
        col_permute(0, 2, 1, -1, -1, -1);
        t = m[1]; m[1] = m[2]; m[2] = t;
        t = m[4]; m[4] = m[5]; m[5] = t;
        continue;
      end
      pos = 0;
      zero = 0;
      for (int i = 0; i < 3; i++) begin
        if (lt(0, m[3+i])) pos++;
        else if (!lt(m[3+i], 0)) zero++;
      end
      if (pos == 3 || (zero == 0 && pos == 1)) begin
        for (int i = 0; i < 3; i++) f[i] = lt(m[3+i], 0) ? -1 : 1;
        col_permute(0, 1, 2, f[0], f[1], f[2]);
        for (int i = 0; i < 3; i++) m[3+i] = clip_metric(sabs(m[3+i]));
      end else begin
        p = -1;
        for (int i = 0; i < 3; i++) begin
          f[i] = 1;
          if (gt(m[3+i], 0)) f[i] = -1;
          else if (!lt(m[3+i], 0)) p = i;
        end
        if (f[0] * f[1] * f[2] < 0 && p >= 0) f[p] = -1;
        col_permute(0, 1, 2, f[0], f[1], f[2]);
        for (int i = 0; i < 3; i++) m[3+i] = clip_metric(sneg(sabs(m[3+i])));
      end
      if (gt(sabs(m[3]), m[1]) || (eq(m[3], m[1]) && lt(sadd(m[4], m[4]), m[5])) ||
          (eq(m[3], sneg(m[1])) && lt(m[5], 0))) begin
        s = sgn(m[3]);
        col_addmul(2, 1, -s);
        m[2] = clip_metric(ssub(sadd(m[1], m[2]), sabs(m[3])));
        m[4] = clip_metric(subsgn(m[4], m[5], s));
        m[3] = clip_metric(subsgn(m[3], sadd(m[1], m[1]), s));
        continue;
      end
      if (gt(sabs(m[4]), m[0]) || (eq(m[4], m[0]) && lt(sadd(m[3], m[3]), m[5])) ||
          (eq(m[4], sneg(m[0])) && lt(m[5], 0))) begin
        s = sgn(m[4]);
        col_addmul(2, 0, -s);
        m[2] = clip_metric(ssub(sadd(m[0], m[2]), sabs(m[4])));
        m[3] = clip_metric(subsgn(m[3], m[5], s));
        m[4] = clip_metric(subsgn(m[4], sadd(m[0], m[0]), s));
        continue;
      end
      if (gt(sabs(m[5]), m[0]) || (eq(m[5], m[0]) && lt(sadd(m[3], m[3]), m[4])) ||
          (eq(m[5], sneg(m[0])) && lt(m[4], 0))) begin
        s = sgn(m[5]);
        col_addmul(1, 0, -s);
        m[1] = clip_metric(ssub(sadd(m[0], m[1]), sabs(m[5])));
        m[3] = clip_metric(subsgn(m[3], m[4], s));
        m[5] = clip_metric(subsgn(m[5], sadd(m[0], m[0]), s));
        continue;
      end
      t = sadd(sadd(sadd(m[3], m[4]), sadd(m[5], m[0])), m[1]);
      if (lt(t, 0) || (eq(t, 0) &&
          gt(sadd(sadd(sadd(m[0], m[4]), sadd(m[0], m[4])), m[5]), 0))) begin
        col_addmul(2, 0, 1);
        col_addmul(2, 1, 1);
        m[2] = clip_metric(sadd(m[2], t));
        m[3] = clip_metric(sadd(sadd(sadd(m[1], m[1]), m[3]), m[5]));
        m[4] = clip_metric(sadd(sadd(sadd(m[0], m[0]), m[4]), m[5]));
        continue;
      end
      break;
    end
    if (st == STATUS_OK && entry_clipped) st = STATUS_SAT;
    res = '0;
    for (int i = 0; i < 6; i++) res.met[i] = m[i][MetricW-1:0];
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) res.col[c][r*EntryW +: EntryW] = basis[r*3+c][EntryW-1:0];
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch in %s: got %h, expected %h", $time, field, got, want);
    error_count_o++;
  endtask

  string met_names[6] = '{"reduced_a", "reduced_b", "reduced_c",
                          "reduced_xi", "reduced_eta", "reduced_zeta"};

  always @(posedge clk_i or negedge rst_ni) begin
    reduction_t got, want;
    if (!rst_ni) begin
      tol_q = TOL_RESET;
      limit_q = LIMIT_RESET;
      error_count_o = 0;
      results_o = 0;
      limit_hits_o = 0;
      saturations_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TOL:   tol_q = cfg_data_i;
          CFG_LIMIT: limit_q = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) expected_q = {expected_q, reduce_metric(s_data_i)};
      if (m_valid_i && m_ready_i) begin
        got = m_data_i[$bits(reduction_t)-1:0];
        results_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(got.status), '0);
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (got.met[i] !== want.met[i]) report_mismatch(met_names[i], got.met[i], want.met[i]);
          for (int c = 0; c < 3; c++)
            if (got.col[c] !== want.col[c])
              report_mismatch($sformatf("basis_column_%0d", c), got.col[c], want.col[c]);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (want.status == STATUS_LIMIT) limit_hits_o++;
          if (want.status == STATUS_SAT) saturations_o++;
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== verif/niggli_cell_reduction_unit_tb.sv =====
`timescale 1ns / 1ps
module niggli_cell_reduction_unit_tb;
  import ncr_pkg::*;

  localparam int WatchdogLimit = 3000000;
  localparam int FRACTION_SHIFT = 24;
  localparam longint MetMax = (64'sd1 <<< (MetricW - 1)) - 1;
  localparam longint MetMin = -MetMax - 1;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  logic             s_ready;
  logic [InW-1:0]   s_data = '0;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OutW-1:0]  m_data;
  logic             cfg_we = 1'b0;
  logic [IdxW-1:0]  cfg_idx = CFG_TOL;
  logic [TolW-1:0]  cfg_data = '0;

  int  errors, pending, results, limit_hits, saturations;
  int  idle_cycles = 0;
  int  items_sent = 0;
  int  rx_stall = 0;
  bit  quiet = 1'b0;
  bit  rx_hold = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  niggli_cell_reduction_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  niggli_cell_reduction_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_valid),
    .s_ready_i     (s_ready),
    .s_data_i      (s_data),
    .m_valid_i     (m_valid),
    .m_ready_i     (m_ready),
    .m_data_i      (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .error_count_o (errors),
    .pending_o     (pending),
    .results_o     (results),
    .limit_hits_o  (limit_hits),
    .saturations_o (saturations)
  );

  always @(negedge clk_i) begin
    if (rx_stall > 0) rx_stall--;
    else if (!quiet && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 11);
    m_ready <= !rx_hold && rx_stall == 0;
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("niggli_cell_reduction_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [InW-1:0] pack_metric(longint a, longint b, longint c,
                                                 longint xi, longint eta, longint zeta);
    logic [5:0][MetricW-1:0] v;
    v[0] = a[MetricW-1:0];
    v[1] = b[MetricW-1:0];
    v[2] = c[MetricW-1:0];
    v[3] = xi[MetricW-1:0];
    v[4] = eta[MetricW-1:0];
    v[5] = zeta[MetricW-1:0];
    return v;
  endfunction

  // metric of a random non-degenerate integer lattice, scaled and jittered
  function automatic logic [InW-1:0] lattice_metric(int span);
    int     v[3][3];
    longint det;
    longint g[6];
    int     sh;
    do begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) v[i][j] = $urandom_range(0, 2 * span) - span;
      det = longint'(v[0][0]) * (v[1][1] * v[2][2] - v[1][2] * v[2][1])
          - longint'(v[0][1]) * (v[1][0] * v[2][2] - v[1][2] * v[2][0])
          + longint'(v[0][2]) * (v[1][0] * v[2][1] - v[1][1] * v[2][0]);
    end while (det == 0);
    g = '{0, 0, 0, 0, 0, 0};
    for (int k = 0; k < 3; k++) begin
      g[0] += v[0][k] * v[0][k];
      g[1] += v[1][k] * v[1][k];
      g[2] += v[2][k] * v[2][k];
      g[3] += 2 * v[1][k] * v[2][k];
      g[4] += 2 * v[0][k] * v[2][k];
      g[5] += 2 * v[0][k] * v[1][k];
    end
    sh = (span > 50) ? 24 - $clog2(span) : $urandom_range(8, FRACTION_SHIFT);
    for (int i = 0; i < 6; i++)
      g[i] = (g[i] <<< sh) + longint'($urandom_range(0, 64)) - 32;
    return pack_metric(g[0], g[1], g[2], g[3], g[4], g[5]);
  endfunction

  function automatic logic [InW-1:0] noise_metric();
    logic [InW-1:0] d;
    for (int i = 0; i < InW / 32; i++) d[i*32 +: 32] = $urandom;
    return d;
  endfunction

  task automatic send_item(input logic [InW-1:0] d);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= d;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [IdxW-1:0] idx, input logic [TolW-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_item();
    logic [InW-1:0] d;
    logic [InW-1:0] noise;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      d = lattice_metric(($urandom_range(0, 15) == 0) ? $urandom_range(20, 1000) :
                         $urandom_range(1, 8));
    end else if (pick == 7) begin
      d = lattice_metric($urandom_range(1, 8));
      noise = noise_metric();
      d[$urandom_range(0, 5)*MetricW +: MetricW] = noise[MetricW-1:0];
    end else begin
      d = noise_metric();
    end
    send_item(d);
  endtask

  initial begin
    longint big_n;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values of tolerance and limit
    repeat (4) send_item(lattice_metric(6));

    // limit of one restart
    write_cfg(CFG_TOL, '0);
    write_cfg(CFG_LIMIT, 16'd1);
    repeat (4) send_item(lattice_metric(6));

    // long skewed cell that runs entries past 16 bits but still converges
    write_cfg(CFG_LIMIT, 16'd65535);
    big_n = 33000;
    send_item(pack_metric(1, big_n * big_n + 1, 64'sd1 <<< 46, 0, 0, 2 * big_n));
    repeat (2) send_item(lattice_metric(6));

    // field extremes and zero terms
    write_cfg(CFG_TOL, 25'd16777216);
    write_cfg(CFG_LIMIT, 16'd60);
    send_item(pack_metric(0, 0, 0, 0, 0, 0));
    send_item(pack_metric(MetMax, MetMax, MetMax, MetMax, MetMax, MetMax));
    send_item(pack_metric(MetMin, MetMin, MetMin, MetMin, MetMin, MetMin));
    send_item(pack_metric(MetMax, MetMin, MetMax, MetMin, MetMax, MetMin));
    send_item(pack_metric(MetMin, MetMax, MetMin, MetMax, MetMin, MetMax));
    send_item(pack_metric(MetMax, MetMax, MetMax, 0, 0, 0));
    send_item(pack_metric(1, 1, 1, MetMin, MetMin, MetMin));
    send_item(pack_metric(64'sd1 <<< 24, 64'sd1 <<< 24, 64'sd1 <<< 24, 0, 0, 0));
    send_item(pack_metric(64'sd1 <<< 24, 64'sd1 <<< 24, 64'sd1 <<< 24,
                          64'sd1 <<< 24, 64'sd1 <<< 24, 64'sd1 <<< 24));
    send_item(pack_metric(64'sd4 <<< 24, 64'sd1 <<< 24, 64'sd9 <<< 24,
                          -(64'sd1 <<< 24), 64'sd3 <<< 24, -(64'sd5 <<< 24)));
    send_item(pack_metric(-(64'sd1 <<< 24), 64'sd2 <<< 24, 0, 0, 64'sd1 <<< 24, 0));
    write_cfg(CFG_TOL, 25'd168);
    send_item(pack_metric(64'sd1 <<< 24, 64'sd1 <<< 24, 64'sd1 <<< 24,
                          -(64'sd1 <<< 24), -(64'sd1 <<< 24), 0));
    send_item(pack_metric(64'sd1 <<< 24, 64'sd1 <<< 24, 64'sd2 <<< 24, 0, 0,
                          64'sd1 <<< 24));

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: write_cfg(CFG_TOL, '0);
        1: write_cfg(CFG_TOL, 25'd16777216);
        2: write_cfg(CFG_TOL, TolW'($urandom_range(0, 1023)));
        default: write_cfg(CFG_TOL, TolW'($urandom_range(0, 16777216)));
      endcase
      write_cfg(CFG_LIMIT, TolW'($urandom_range(20, 80)));
      quiet = (ph == 7) || (ph == 5);
      if (ph == 2) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 210; k++) begin
        if (ph == 4 && k == 100) drain();
        random_item();
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    $display("reduced %0d metrics (%0d results) over directed extremes and random lattices",
             items_sent, results);
    $display("limit exits %0d, saturated matrices %0d, mismatches %0d",
             limit_hits, saturations, errors);
    if (errors == 0 && pending == 0) begin
      $display("niggli_cell_reduction_unit_tb: PASS");
    end else begin
      $display("niggli_cell_reduction_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ncr_pkg.sv
design/ncr_ctrl.sv
design/ncr_datapath.sv
design/niggli_cell_reduction_unit.sv
verif/niggli_cell_reduction_checker.sv
verif/niggli_cell_reduction_unit_tb.sv
